// ----- src/cfm_pkg.sv -----
// shared types, constants and helpers of the crossfade mixer
package cfm_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int CHANNELS      = 8;
    localparam int CHAN_BITS     = $clog2(CHANNELS);
    localparam int GAIN_BITS     = 17;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 17;
    localparam int ROOT_IN_BITS  = 33;

    // fixed point constants
    localparam logic [GAIN_BITS-1:0] GAIN_ONE      = 17'h10000;
    localparam logic [16:0]          FADE_RESET    = 17'd0;
    localparam logic [16:0]          LEVEL_RESET   = 17'd16384;
    localparam logic [3:0]           ACTIVE_RESET  = 4'd4;
    localparam logic [3:0]           ACTIVE_MIN    = 4'd2;
    localparam logic [3:0]           ACTIVE_MAX    = 4'd8;
    localparam logic [16:0]          DECLICK_RESET = 17'd454;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_FADE    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LEVEL   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ACTIVE  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SNAP    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DECLICK = 3'd4;

    // input frame
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_one;
        logic signed [SAMPLE_BITS-1:0] sample_two;
        logic signed [SAMPLE_BITS-1:0] sample_three;
        logic signed [SAMPLE_BITS-1:0] sample_four;
        logic signed [SAMPLE_BITS-1:0] sample_five;
        logic signed [SAMPLE_BITS-1:0] sample_six;
        logic signed [SAMPLE_BITS-1:0] sample_seven;
        logic signed [SAMPLE_BITS-1:0] sample_eight;
    } t_in_item;

    // mixed result
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] mixed_sample;
        logic                          clipped;
    } t_out_item;

    // configuration after range limiting
    typedef struct packed {
        logic [16:0] fade;
        logic [16:0] level;
        logic [3:0]  active;
        logic        snap;
        logic [16:0] coeff;
    } t_mix_cfg;

    // square root unit control and status
    typedef struct packed {
        logic                    start;
        logic [ROOT_IN_BITS-1:0] radicand;
    } t_sqrt_req;

    typedef struct packed {
        logic                 busy;
        logic [GAIN_BITS-1:0] root;
    } t_sqrt_rsp;

    // pick one input sample by channel number
    function automatic logic signed [SAMPLE_BITS-1:0] sample_at(
        input t_in_item             item,
        input logic [CHAN_BITS-1:0] idx
    );
        logic signed [SAMPLE_BITS-1:0] s;
        unique case (idx)
            3'd0:    s = item.sample_one;
            3'd1:    s = item.sample_two;
            3'd2:    s = item.sample_three;
            3'd3:    s = item.sample_four;
            3'd4:    s = item.sample_five;
            3'd5:    s = item.sample_six;
            3'd6:    s = item.sample_seven;
            default: s = item.sample_eight;
        endcase
        return s;
    endfunction

endpackage

// ----- src/cfm_sqrt.sv -----
// iterative integer square root, one result bit per cycle
module cfm_sqrt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cfm_pkg::t_sqrt_req i_req,
    output cfm_pkg::t_sqrt_rsp o_rsp
);
    import cfm_pkg::*;

    localparam int RES_BITS = ROOT_IN_BITS + 2;
    localparam logic [ROOT_IN_BITS-1:0] TOP_BIT = ROOT_IN_BITS'(1) << (ROOT_IN_BITS - 1);

    logic [ROOT_IN_BITS-1:0] r_v;
    logic [RES_BITS-1:0]     r_res;
    logic [ROOT_IN_BITS-1:0] r_bit;
    logic [RES_BITS-1:0]     n_sum;
    logic                    n_fits;

    // trial subtraction of the current bit
    assign n_sum  = r_res + RES_BITS'(r_bit);
    assign n_fits = RES_BITS'(r_v) >= n_sum;

    // bit position walks down two places per step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= '0;
        end else if (i_req.start) begin
            r_bit <= TOP_BIT;
        end else if (r_bit != '0) begin
            r_bit <= r_bit >> 2;
        end
    end

    // remainder and partial root
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_v   <= i_req.radicand;
            r_res <= '0;
        end else if (r_bit != '0) begin
            if (n_fits) begin
                r_v   <= r_v - ROOT_IN_BITS'(n_sum);
                r_res <= (r_res >> 1) + RES_BITS'(r_bit);
            end else begin
                r_res <= r_res >> 1;
            end
        end
    end

    assign o_rsp.busy = r_bit != '0;
    assign o_rsp.root = r_res[GAIN_BITS-1:0];

endmodule

// ----- src/cfm_engine.sv -----
// channel sequencer with gain memory, gain smoothing and weighted sum
module cfm_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  cfm_pkg::t_in_item  i_item,
    input  cfm_pkg::t_mix_cfg  i_cfg,
    output logic               o_idle,
    input  logic               i_out_free,
    output logic               o_res_valid,
    output cfm_pkg::t_out_item o_res,
    output cfm_pkg::t_sqrt_req o_sqrt_req,
    input  cfm_pkg::t_sqrt_rsp i_sqrt_rsp
);
    import cfm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SETUP, S_READ, S_TARGET, S_PROD, S_STEP,
        S_MAC, S_ACC, S_MIX, S_SAT, S_DONE
    } t_state;

    localparam int POS_BITS  = 19;
    localparam int PROD_BITS = 36;
    localparam int STEP_BITS = PROD_BITS - 16;
    localparam int TERM_BITS = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int ACC_BITS  = TERM_BITS + CHAN_BITS;
    localparam int MIX_BITS  = ACC_BITS - 16;
    localparam int MP_BITS   = MIX_BITS + 18;
    localparam int RES_BITS  = MP_BITS - 14;
    localparam logic signed [RES_BITS-1:0] SAT_HI = RES_BITS'((64'sd1 <<< (SAMPLE_BITS-1)) - 1);
    localparam logic signed [RES_BITS-1:0] SAT_LO = -RES_BITS'(64'sd1 <<< (SAMPLE_BITS-1));

    t_state                        r_state;
    t_in_item                      r_item;
    logic [CHAN_BITS-1:0]          r_chan;
    logic [CHAN_BITS-1:0]          r_last;
    logic [16:0]                   r_fade;
    logic [16:0]                   r_level;
    logic [16:0]                   r_coeff;
    logic                          r_snap;
    logic [POS_BITS-1:0]           r_pos;
    logic [GAIN_BITS-1:0]          r_tgt;
    logic signed [17:0]            r_diff;
    logic signed [PROD_BITS-1:0]   r_prod;
    logic [GAIN_BITS-1:0]          r_gain;
    logic signed [TERM_BITS-1:0]   r_term;
    logic signed [ACC_BITS-1:0]    r_acc;
    logic signed [MP_BITS-1:0]     r_mixprod;
    logic signed [SAMPLE_BITS-1:0] r_res;
    logic                          r_clip;

    // gain memory with per-entry valid bits for the zero reset
    logic [GAIN_BITS-1:0] r_gain_mem [CHANNELS];
    logic [CHANNELS-1:0]  r_gain_vld;
    logic [GAIN_BITS-1:0] r_rd_data;
    logic                 r_rd_vld;

    logic [GAIN_BITS-1:0]        n_old_gain;
    logic [POS_BITS-1:0]         n_sel_sum;
    logic [CHAN_BITS-1:0]        n_sel_raw;
    logic [CHAN_BITS-1:0]        n_sel;
    logic signed [POS_BITS:0]    n_dist;
    logic [POS_BITS-1:0]         n_dabs;
    logic [GAIN_BITS-1:0]        n_lin;
    logic signed [17:0]          n_diff;
    logic signed [PROD_BITS-1:0] n_round;
    logic signed [STEP_BITS-1:0] n_step;
    logic signed [STEP_BITS-1:0] n_sum_gain;
    logic [GAIN_BITS-1:0]        n_gain;
    logic                        n_we;
    logic signed [ACC_BITS-1:0]  n_acc_rnd;
    logic signed [MIX_BITS-1:0]  n_mix;
    logic signed [MP_BITS-1:0]   n_mp_rnd;
    logic signed [RES_BITS-1:0]  n_res;

    // stored gain, zero until first written
    assign n_old_gain = r_rd_vld ? r_rd_data : '0;

    // nearest input for snap mode, ties go up
    assign n_sel_sum = r_pos + POS_BITS'(32768);
    assign n_sel_raw = n_sel_sum[POS_BITS-1:16];
    assign n_sel     = (n_sel_raw > r_last) ? r_last : n_sel_raw;

    // linear weight 1 - min(1, |pos - c|)
    assign n_dist = $signed({1'b0, r_pos}) - $signed({1'b0, r_chan, 16'b0});
    assign n_dabs = n_dist[POS_BITS] ? POS_BITS'(-n_dist) : POS_BITS'(n_dist);
    assign n_lin  = (n_dabs > POS_BITS'(GAIN_ONE)) ? '0 : GAIN_BITS'(POS_BITS'(GAIN_ONE) - n_dabs);

    assign o_sqrt_req.start    = (r_state == S_READ) && !r_snap;
    assign o_sqrt_req.radicand = {n_lin, 16'b0};

    // one-pole step with a minimum of one count toward the target
    assign n_diff  = $signed({1'b0, r_tgt}) - $signed({1'b0, n_old_gain});
    assign n_round = r_prod + PROD_BITS'(32768);
    always_comb begin
        n_step = n_round[PROD_BITS-1:16];
        if (n_step == '0 && r_diff != '0) begin
            n_step = r_diff[17] ? -STEP_BITS'(1) : STEP_BITS'(1);
        end
    end
    assign n_sum_gain = $signed({{(STEP_BITS-GAIN_BITS){1'b0}}, n_old_gain}) + n_step;
    assign n_gain     = n_sum_gain[GAIN_BITS-1:0];
    assign n_we       = r_state == S_STEP;

    // rounding of the sum and of the level product
    assign n_acc_rnd = r_acc + ACC_BITS'(32768);
    assign n_mix     = n_acc_rnd[ACC_BITS-1:16];
    assign n_mp_rnd  = r_mixprod + MP_BITS'(8192);
    assign n_res     = n_mp_rnd[MP_BITS-1:14];

    // gain memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_gain_mem[r_chan] <= n_gain;
        end
        r_rd_data <= r_gain_mem[r_chan];
    end

    // valid bits of the gain memory
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_vld <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            if (n_we) begin
                r_gain_vld[r_chan] <= 1'b1;
            end
            r_rd_vld <= r_gain_vld[r_chan];
        end
    end

    // sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_chan  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_item  <= i_item;
                        r_last  <= CHAN_BITS'(i_cfg.active - 4'd1);
                        r_fade  <= i_cfg.fade;
                        r_level <= i_cfg.level;
                        r_snap  <= i_cfg.snap;
                        r_coeff <= i_cfg.snap ? i_cfg.coeff : GAIN_ONE;
                        r_acc   <= '0;
                        r_chan  <= '0;
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_pos   <= POS_BITS'(r_fade) * POS_BITS'(r_last);
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_state <= S_TARGET;
                end
                S_TARGET: begin
                    if (r_snap) begin
                        r_tgt   <= (r_chan == n_sel) ? GAIN_ONE : '0;
                        r_state <= S_PROD;
                    end else if (!i_sqrt_rsp.busy) begin
                        r_tgt   <= i_sqrt_rsp.root;
                        r_state <= S_PROD;
                    end
                end
                S_PROD: begin
                    r_diff  <= n_diff;
                    r_prod  <= $signed({1'b0, r_coeff}) * n_diff;
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    r_gain  <= n_gain;
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    r_term  <= sample_at(r_item, r_chan) * $signed({1'b0, r_gain});
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc <= r_acc + ACC_BITS'(r_term);
                    if (r_chan == r_last) begin
                        r_state <= S_MIX;
                    end else begin
                        r_chan  <= r_chan + CHAN_BITS'(1);
                        r_state <= S_READ;
                    end
                end
                S_MIX: begin
                    r_mixprod <= n_mix * $signed({1'b0, r_level});
                    r_state   <= S_SAT;
                end
                S_SAT: begin
                    if (n_res > SAT_HI) begin
                        r_res  <= SAT_HI[SAMPLE_BITS-1:0];
                        r_clip <= 1'b1;
                    end else if (n_res < SAT_LO) begin
                        r_res  <= SAT_LO[SAMPLE_BITS-1:0];
                        r_clip <= 1'b1;
                    end else begin
                        r_res  <= n_res[SAMPLE_BITS-1:0];
                        r_clip <= 1'b0;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_idle             = r_state == S_IDLE;
    assign o_res_valid        = r_state == S_DONE;
    assign o_res.mixed_sample = r_res;
    assign o_res.clipped      = r_clip;

    // channel index never runs past the active count
    a_chan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_SETUP) |-> (r_chan <= r_last))
        else $error("channel index beyond active inputs");

    // smoothing never overshoots unity gain
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_we |-> (n_gain <= GAIN_ONE))
        else $error("gain written above unity");

    // square root is only started when free
    a_sqrt_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sqrt_req.start |-> !i_sqrt_rsp.busy)
        else $error("square root started while busy");

    // a finished result waits for the output slot
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_out_free) |=> (o_res_valid && $stable(r_res)))
        else $error("result lost before it was taken");

endmodule

// ----- src/equal_power_crossfade_mixer.sv -----
// top level: configuration registers, engine, square root unit and output register
//
// Usage
//   Input channel: a frame of eight signed samples is a request on i_in_valid,
//   taken at an edge where o_in_stall is low. Output channel: one mixed sample
//   and a clip flag per frame on o_out_valid, taken where i_out_stall is low.
//   Configuration: i_cfg_valid with i_cfg_index / i_cfg_data, always ready;
//   write only while the block is idle. Unknown indexes are ignored.
//   Sequencing: the engine visits the n active inputs one after another. In
//   smooth mode each input waits on the bit-serial square root (17 steps)
//   besides its read, multiply and accumulate steps; snap mode runs no square
//   root. A frame occupies the engine until its result enters the output
//   register.
//   The output register holds one finished result, so the next frame is taken
//   while it waits; a stalled receiver holds the engine at its last step.
//   Reset sets the registers to their defaults and all channel gains to zero.
module equal_power_crossfade_mixer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  cfm_pkg::t_in_item                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output cfm_pkg::t_out_item                  o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cfm_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [cfm_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import cfm_pkg::*;

    logic [16:0] r_fade;
    logic [16:0] r_level;
    logic [3:0]  r_active;
    logic        r_snap;
    logic [16:0] r_coeff;
    t_mix_cfg    n_cfg;
    logic        n_idle;
    logic        n_out_free;
    logic        n_res_valid;
    t_out_item   n_res;
    t_sqrt_req   n_sqrt_req;
    t_sqrt_rsp   n_sqrt_rsp;
    logic        r_out_valid;
    t_out_item   r_out;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade   <= FADE_RESET;
            r_level  <= LEVEL_RESET;
            r_active <= ACTIVE_RESET;
            r_snap   <= 1'b0;
            r_coeff  <= DECLICK_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_FADE:    r_fade   <= i_cfg_data;
                CFG_LEVEL:   r_level  <= i_cfg_data;
                CFG_ACTIVE:  r_active <= i_cfg_data[3:0];
                CFG_SNAP:    r_snap   <= i_cfg_data[0];
                CFG_DECLICK: r_coeff  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // range limits on the registers
    assign n_cfg.fade   = (r_fade > GAIN_ONE) ? GAIN_ONE : r_fade;
    assign n_cfg.level  = (r_level > GAIN_ONE) ? GAIN_ONE : r_level;
    assign n_cfg.active = (r_active < ACTIVE_MIN) ? ACTIVE_MIN :
                          (r_active > ACTIVE_MAX) ? ACTIVE_MAX : r_active;
    assign n_cfg.snap   = r_snap;
    assign n_cfg.coeff  = (r_coeff > GAIN_ONE) ? GAIN_ONE : r_coeff;

    // input handshake
    assign o_in_stall = !n_idle;

    cfm_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in_valid && n_idle),
        .i_item      (i_in_data),
        .i_cfg       (n_cfg),
        .o_idle      (n_idle),
        .i_out_free  (n_out_free),
        .o_res_valid (n_res_valid),
        .o_res       (n_res),
        .o_sqrt_req  (n_sqrt_req),
        .i_sqrt_rsp  (n_sqrt_rsp)
    );

    cfm_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_sqrt_req),
        .o_rsp   (n_sqrt_rsp)
    );

    // output register, free when empty or being taken
    assign n_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_res_valid && n_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_res_valid && n_out_free) begin
            r_out <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
